[rtl/core/homing_cycle_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// homing_cycle_sequencer_macros.svh
// Assertion macros for the homing sequencer; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef HOMING_CYCLE_SEQUENCER_MACROS_SVH
`define HOMING_CYCLE_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define HCS_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define HCS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define HCS_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg)

`define HCS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

[rtl/core/hcs_pkg.sv]
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared types and constants of the homing sequencer.
// ----------------------------------------------------------------------------
package hcs_pkg;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_Z     = 2'd1,
		PH_XYC   = 2'd2,
		PH_LEAVE = 2'd3
	} hcs_phase_t;

	typedef enum logic [2:0] {
		REG_HOME_AXES    = 3'd0,
		REG_INVERT_STEP  = 3'd1,
		REG_INVERT_DIR   = 3'd2,
		REG_INVERT_LIMIT = 3'd3,
		REG_PULSE_TICKS  = 3'd4,
		REG_SEEK_PERIOD  = 3'd5,
		REG_FEED_PERIOD  = 3'd6,
		REG_DEBOUNCE     = 3'd7
	} hcs_reg_t;

	localparam int unsigned FIELD_W = 4;	// width of per-axis port fields
	localparam int unsigned Z_AXIS  = 2;

	localparam logic [7:0]  PULSE_RST    = 8'd10;
	localparam logic [15:0] SEEK_RST     = 16'd1000;
	localparam logic [15:0] FEED_RST     = 16'd2000;
	localparam logic [7:0]  DEBOUNCE_RST = 8'd10;
	localparam logic [7:0]  CNT_MAX      = 8'hFF;

	typedef struct packed {
		logic [FIELD_W-1:0] home_axes;
		logic [FIELD_W-1:0] invert_step;
		logic [FIELD_W-1:0] invert_dir;
		logic [FIELD_W-1:0] invert_limit;
		logic [7:0]         pulse_ticks;
		logic [15:0]        seek_period;
		logic [15:0]        feed_period;
		logic [7:0]         debounce_count;
	} hcs_cfg_t;

	typedef struct packed {
		logic [FIELD_W-1:0] step_lines;
		logic [FIELD_W-1:0] dir_lines;
		logic               busy;
		hcs_phase_t         phase;
		logic               done;
	} hcs_res_t;

endpackage

[rtl/core/hcs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// hcs_cfg_regs
// Configuration register file, written by index over the config channel.
// ----------------------------------------------------------------------------
module hcs_cfg_regs
	import hcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data,
	output hcs_cfg_t    cfg
);

	hcs_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.home_axes      <= '0;
			cfg_q.invert_step    <= '0;
			cfg_q.invert_dir     <= '0;
			cfg_q.invert_limit   <= '0;
			cfg_q.pulse_ticks    <= PULSE_RST;
			cfg_q.seek_period    <= SEEK_RST;
			cfg_q.feed_period    <= FEED_RST;
			cfg_q.debounce_count <= DEBOUNCE_RST;
		end else if (wr_en) begin
			case (hcs_reg_t'(wr_index))
				REG_HOME_AXES:    cfg_q.home_axes      <= wr_data[FIELD_W-1:0];
				REG_INVERT_STEP:  cfg_q.invert_step    <= wr_data[FIELD_W-1:0];
				REG_INVERT_DIR:   cfg_q.invert_dir     <= wr_data[FIELD_W-1:0];
				REG_INVERT_LIMIT: cfg_q.invert_limit   <= wr_data[FIELD_W-1:0];
				REG_PULSE_TICKS:  cfg_q.pulse_ticks    <= wr_data[7:0];
				REG_SEEK_PERIOD:  cfg_q.seek_period    <= wr_data;
				REG_FEED_PERIOD:  cfg_q.feed_period    <= wr_data;
				REG_DEBOUNCE:     cfg_q.debounce_count <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/hcs_axis_lane.sv]
// ----------------------------------------------------------------------------
// hcs_axis_lane
// Debounce counter of one axis; flags the axis as stopped.
// ----------------------------------------------------------------------------
module hcs_axis_lane
	import hcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample,
	input  logic       active,
	input  logic       sense,
	input  logic       clear,
	input  logic [7:0] debounce_count,
	output logic       stop
);

	logic [7:0] cnt_q;
	logic [7:0] cnt_next;

	// low sense = switch active; counter saturates
	always_comb begin
		if (!sense) begin
			cnt_next = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 8'd1;
		end else begin
			cnt_next = '0;
		end
	end

	assign stop = active && (cnt_next >= debounce_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clear) begin
			cnt_q <= '0;
		end else if (sample && active) begin
			cnt_q <= cnt_next;
		end
	end

endmodule

[rtl/core/hcs_seq_core.sv]
// ----------------------------------------------------------------------------
// hcs_seq_core
// Phase, axis and period timer state; one update per transfer.
// ----------------------------------------------------------------------------
module hcs_seq_core
	import hcs_pkg::*;
#(
	parameter int unsigned AXES = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic               kind,
	input  logic [FIELD_W-1:0] pins,
	input  hcs_cfg_t           cfg,
	output hcs_res_t           res
);

	localparam int unsigned NB = (AXES < FIELD_W) ? AXES : FIELD_W;
	localparam logic [AXES-1:0] Z_MASK =
		(AXES > Z_AXIS) ? (AXES'(1) << Z_AXIS) : '0;

	hcs_phase_t      phase_q, phase_new;
	logic [AXES-1:0] active_q, active_post, active_new;
	logic [15:0]     timer_q, timer_new;

	logic [AXES-1:0] home_w, inv_step_w, inv_dir_w, inv_lim_w, pins_w;
	logic [AXES-1:0] sense, stop, pulse_mask, dir_w;
	logic            tick, start, sample, end_phase, stepping, clear;
	logic [15:0]     per_sel, per_max, per_eff, pulse_w;
	logic [16:0]     pos_next;
	hcs_phase_t      phase_nxt;

	// map the 4-bit fields onto the axis vector
	always_comb begin
		home_w     = '0;
		inv_step_w = '0;
		inv_dir_w  = '0;
		inv_lim_w  = '0;
		pins_w     = '0;
		home_w[NB-1:0]     = cfg.home_axes[NB-1:0];
		inv_step_w[NB-1:0] = cfg.invert_step[NB-1:0];
		inv_dir_w[NB-1:0]  = cfg.invert_dir[NB-1:0];
		inv_lim_w[NB-1:0]  = cfg.invert_limit[NB-1:0];
		pins_w[NB-1:0]     = pins[NB-1:0];
	end

	assign tick   = fire && !kind;
	assign start  = fire && kind && (phase_q == PH_IDLE);
	assign sample = tick && (phase_q != PH_IDLE) && (timer_q == 16'd0);
	assign sense  = pins_w ^ inv_lim_w ^ ((phase_q == PH_LEAVE) ? '1 : '0);

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		hcs_axis_lane u_lane (
			.clk            (clk),
			.arst_n         (arst_n),
			.sample         (sample),
			.active         (active_q[a]),
			.sense          (sense[a]),
			.clear          (clear),
			.debounce_count (cfg.debounce_count),
			.stop           (stop[a])
		);
	end

	assign active_post = sample ? (active_q & ~stop) : active_q;
	assign end_phase   = sample && (active_post == '0);
	assign stepping    = tick && (phase_q != PH_IDLE) && !end_phase;
	assign clear       = start || end_phase;

	always_comb begin
		case (phase_q)
			PH_Z:     phase_nxt = PH_XYC;
			PH_XYC:   phase_nxt = PH_LEAVE;
			default:  phase_nxt = PH_IDLE;
		endcase
	end

	assign phase_new = start ? PH_Z : (end_phase ? phase_nxt : phase_q);

	// axes loaded on entry to a phase
	always_comb begin
		case (phase_new)
			PH_Z:     active_new = home_w & Z_MASK;
			PH_XYC:   active_new = home_w & ~Z_MASK;
			PH_LEAVE: active_new = home_w;
			default:  active_new = '0;
		endcase
	end

	// period = max(phase period, pulse width, 1)
	assign pulse_w  = {8'd0, cfg.pulse_ticks};
	assign per_sel  = (phase_q == PH_LEAVE) ? cfg.feed_period : cfg.seek_period;
	assign per_max  = (per_sel < pulse_w) ? pulse_w : per_sel;
	assign per_eff  = (per_max == 16'd0) ? 16'd1 : per_max;
	assign pos_next = {1'b0, timer_q} + 17'd1;

	always_comb begin
		if (clear) begin
			timer_new = '0;
		end else if (stepping) begin
			timer_new = (pos_next >= {1'b0, per_eff}) ? 16'd0 : pos_next[15:0];
		end else begin
			timer_new = timer_q;
		end
	end

	assign pulse_mask = (stepping && (timer_q < pulse_w)) ? active_post : '0;
	assign dir_w = ((phase_new == PH_Z) || (phase_new == PH_XYC)) ? '1 : '0;

	always_comb begin
		res            = '0;
		res.step_lines[NB-1:0] = pulse_mask[NB-1:0] ^ inv_step_w[NB-1:0];
		res.dir_lines[NB-1:0]  = dir_w[NB-1:0] ^ inv_dir_w[NB-1:0];
		res.busy       = (phase_new != PH_IDLE);
		res.phase      = phase_new;
		res.done       = end_phase && (phase_q == PH_LEAVE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			active_q <= '0;
			timer_q  <= '0;
		end else if (fire) begin
			phase_q  <= phase_new;
			active_q <= clear ? active_new : active_post;
			timer_q  <= timer_new;
		end
	end

endmodule

[rtl/core/homing_cycle_sequencer.sv]
// ----------------------------------------------------------------------------
// homing_cycle_sequencer
// Limit-switch homing sequencer: Z approach, X/Y/C approach, back-off.
//
// Input channel (in_valid/in_ready): one transfer per 1 us tick (kind 0) or a
// start request (kind 1, dropped while a sequence runs), with raw limit pins.
// Output channel (out_valid/out_ready): exactly one result per input item:
// step and direction line levels, busy flag, phase and the done strobe.
// Config channel (cfg_valid/cfg_ready): register index and data, always ready;
// write only while no item is in flight.
// Throughput is one item per cycle while the receiver takes results; the whole
// update of phase, axis mask, debounce counters and period timer is one pass
// between the input register and the result register. A result is offered once
// its item has moved on from the input register into the result register.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; in_ready drops only when both are full.
// Reset clears both stages, puts the sequencer in idle with all counters at
// zero and loads the register defaults (pulse 10, seek 1000, feed 2000,
// debounce 10 ticks).
// ----------------------------------------------------------------------------
module homing_cycle_sequencer
	import hcs_pkg::*;
#(
	parameter int unsigned AXES = 4
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [FIELD_W-1:0] limit_pins,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [FIELD_W-1:0] step_lines,
	output logic [FIELD_W-1:0] dir_lines,
	output logic               busy_res,
	output logic [1:0]         phase_now,
	output logic               home_done,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

`include "homing_cycle_sequencer_macros.svh"

	hcs_cfg_t           cfg;
	hcs_res_t           res;
	hcs_res_t           res_s2;
	logic               valid_s1, valid_s2;
	logic               kind_s1;
	logic [FIELD_W-1:0] pins_s1;
	logic               advance, fire, in_xfer;

	// config is taken every cycle
	assign cfg_ready = 1'b1;

	hcs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// stage 1 moves on when the result slot is free or being drained
	assign advance  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// input payload register
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_s1 <= kind;
			pins_s1 <= limit_pins;
		end
	end

	hcs_seq_core #(
		.AXES (AXES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.kind   (kind_s1),
		.pins   (pins_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign step_lines = res_s2.step_lines;
	assign dir_lines  = res_s2.dir_lines;
	assign busy_res   = res_s2.busy;
	assign phase_now  = res_s2.phase;
	assign home_done  = res_s2.done;

	// back-pressure reaches the input only with both stages full and stalled
	`HCS_ASSERT_NOW(a_ready_only_full, clk, arst_n, !in_ready,
		valid_s1 && valid_s2 && !out_ready, "in_ready low without a full stall")

	// an item in stage 1 with a free result slot shows up next cycle
	`HCS_ASSERT_NEXT(a_s1_drains, clk, arst_n, valid_s1 && !valid_s2, out_valid,
		"stage 1 item did not reach the result register")

	// a new result only ever comes from stage 1
	`HCS_ASSERT_NOW(a_result_source, clk, arst_n, $rose(out_valid), $past(valid_s1),
		"result appeared without an item in stage 1")

endmodule
